// ===== sv/pst_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pst_pkg
// Shared constants, types and helper functions of the pot soft takeover block.
// ---------------------------------------------------------------------------
package pst_pkg;

  localparam int POT_COUNT    = 6;
  localparam int MODE_COUNT   = 4;
  localparam int ADC_BITS     = 12;
  localparam int WINDOW_RESET = 10;

  localparam int SAMPLE_W    = ADC_BITS;
  localparam int LEVEL_W     = ADC_BITS + 1;
  localparam int POT_W       = 3;
  localparam int MODE_W      = 2;
  localparam int MASK_W      = POT_COUNT;
  localparam int WINDOW_W    = 12;
  localparam int STORE_DEPTH = POT_COUNT * MODE_COUNT;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEVEL_W-1:0] HALF_SCALE = LEVEL_W'(1) << (ADC_BITS - 1);
  localparam logic [LEVEL_W-1:0] LOW_LEVEL  = LEVEL_W'(1);
  localparam logic [MODE_W-1:0]  MODE_RESET = MODE_W'(3);

  typedef struct packed {
    logic                mode_chg;
    logic                pot_ok;
    logic [POT_W-1:0]    pot;
    logic [MODE_W-1:0]   mode;
    logic [LEVEL_W-1:0]  level;
  } pst_entry_t;

  function automatic logic [SAMPLE_W-1:0] mid3(input logic [SAMPLE_W-1:0] a,
                                                input logic [SAMPLE_W-1:0] b,
                                                input logic [SAMPLE_W-1:0] c);
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] res;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      res = lo;
    end else if (c >= hi) begin
      res = hi;
    end else begin
      res = c;
    end
    return res;
  endfunction

  function automatic logic [LEVEL_W-1:0] default_level(input int p, input int m);
    logic [LEVEL_W-1:0] v;
    v = LOW_LEVEL;
    if (m == 0 && (p == 1 || p == 3)) begin
      v = HALF_SCALE;
    end else if ((m == 2 || m == 3) && (p == 2 || p == 5)) begin
      v = HALF_SCALE;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/pst_ifs.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pst_ifs
// Valid/ready channel interfaces for samples, results and configuration.
// ---------------------------------------------------------------------------
interface pst_in_if;
  import pst_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          button_state;
  logic [POT_W-1:0]    pot_index;
  logic [SAMPLE_W-1:0] sample_first;
  logic [SAMPLE_W-1:0] sample_second;
  logic [SAMPLE_W-1:0] sample_third;

  modport source (output valid, button_state, pot_index, sample_first,
                  sample_second, sample_third, input ready);
  modport sink (input valid, button_state, pot_index, sample_first,
                sample_second, sample_third, output ready);
endinterface

interface pst_out_if;
  import pst_pkg::*;
  logic               valid;
  logic               ready;
  logic [POT_W-1:0]   pot_out;
  logic [MODE_W-1:0]  mode_out;
  logic [LEVEL_W-1:0] level;
  logic               value_updated;
  logic [MASK_W-1:0]  control_mask;

  modport source (output valid, pot_out, mode_out, level, value_updated,
                  control_mask, input ready);
  modport sink (input valid, pot_out, mode_out, level, value_updated,
                control_mask, output ready);
endinterface

interface pst_cfg_if;
  import pst_pkg::*;
  logic                valid;
  logic                ready;
  logic [WINDOW_W-1:0] pickup_window;

  modport source (output valid, pickup_window, input ready);
  modport sink (input valid, pickup_window, output ready);
endinterface
`default_nettype wire

// ===== sv/pot_soft_takeover.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pot_soft_takeover
// Soft takeover for a bank of potentiometers shared across button modes.
// ---------------------------------------------------------------------------
// The block takes one sample transfer per clock while the queue is not full
// and delivers one result per transfer, in order; each transfer is written
// into the queue and popped into the result register when that register is
// empty or its result is being taken. The back end reads, compares and writes
// the per-pot stored level table as it pops each item. A two-entry queue
// separates the front from the back end, so up to two further transfers are
// taken while a result waits before the input stalls. The pickup window
// register is always ready and should be written only while no item is in
// flight.
module pot_soft_takeover (
  input  wire logic clk,
  input  wire logic rst_n,
  pst_in_if.sink    in_ch,
  pst_cfg_if.sink   cfg_ch,
  pst_out_if.source out_ch
);
  import pst_pkg::*;

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  pst_entry_t q_in;
  pst_entry_t q_head;

  pst_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  pst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  pst_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// ===== sv/pst_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pst_front
// Accepts sample transfers, filters the level and tracks the button mode.
// ---------------------------------------------------------------------------
module pst_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  pst_in_if.sink                in_ch,
  input  wire logic             q_full,
  output logic                  q_push,
  output pst_pkg::pst_entry_t   q_entry
);
  import pst_pkg::*;

  logic [1:0]        last_buttons_r;
  logic [1:0]        last_buttons_nxt;
  logic [MODE_W-1:0] current_mode_r;
  logic [MODE_W-1:0] current_mode_nxt;
  logic              accept;
  logic              chg;
  logic [MODE_W-1:0] mode_new;

  always_comb begin
    in_ch.ready      = !q_full;
    accept           = in_ch.valid && !q_full;
    chg              = in_ch.button_state != last_buttons_r;
    mode_new         = chg ? in_ch.button_state : current_mode_r;
    last_buttons_nxt = accept ? in_ch.button_state : last_buttons_r;
    current_mode_nxt = accept ? mode_new : current_mode_r;

    q_push           = accept;
    q_entry.mode_chg = chg;
    q_entry.pot_ok   = int'(in_ch.pot_index) < POT_COUNT;
    q_entry.pot      = in_ch.pot_index;
    q_entry.mode     = mode_new;
    q_entry.level    = LEVEL_W'(mid3(in_ch.sample_first, in_ch.sample_second,
                                     in_ch.sample_third)) + LEVEL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_buttons_r <= MODE_RESET;
      current_mode_r <= MODE_RESET;
    end else begin
      last_buttons_r <= last_buttons_nxt;
      current_mode_r <= current_mode_nxt;
    end
  end

`ifndef SYNTHESIS
  a_mode_follows_buttons: assert property (@(posedge clk) disable iff (!rst_n)
    accept && chg |=> current_mode_r == $past(in_ch.button_state))
    else $error("mode did not follow a button change");
`endif

endmodule
`default_nettype wire

// ===== sv/pst_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pst_queue
// Short FIFO that decouples the classifying front from the table back end.
// ---------------------------------------------------------------------------
module pst_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire pst_pkg::pst_entry_t push_entry,
  input  wire logic                pop,
  output logic                     full,
  output logic                     empty,
  output pst_pkg::pst_entry_t      head
);
  import pst_pkg::*;

  pst_entry_t        slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    full    = count_r == QCNT_W'(QUEUE_DEPTH);
    empty   = count_r == '0;
    head    = slots_r[rd_ptr_r];
    do_push = push && !full;
    do_pop  = pop && !empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    count_nxt = count_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into a full queue");
`endif

endmodule
`default_nettype wire

// ===== sv/pst_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pst_back
// Per-pot stored level table, pickup decision, control mask and result register.
// ---------------------------------------------------------------------------
module pst_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire pst_pkg::pst_entry_t q_head,
  output logic                     q_pop,
  pst_cfg_if.sink                  cfg_ch,
  pst_out_if.source                out_ch
);
  import pst_pkg::*;

  logic [LEVEL_W-1:0]  store_r [STORE_DEPTH];
  logic [WINDOW_W-1:0] window_r;
  logic [WINDOW_W-1:0] window_nxt;
  logic [MASK_W-1:0]   held_r;
  logic [MASK_W-1:0]   held_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [POT_W-1:0]    pot_r;
  logic [MODE_W-1:0]   mode_r;
  logic [LEVEL_W-1:0]  level_r;
  logic                updated_r;

  logic [MASK_W-1:0]   held_base;
  logic [MASK_W-1:0]   pot_bit;
  logic [SLOT_W-1:0]   slot;
  logic                active;
  logic [LEVEL_W-1:0]  stored;
  logic [LEVEL_W-1:0]  gap;
  logic                take;

  always_comb begin
    cfg_ch.ready = 1'b1;
    window_nxt   = cfg_ch.valid ? cfg_ch.pickup_window : window_r;

    q_pop     = !q_empty && (!out_valid_r || out_ch.ready);
    held_base = q_head.mode_chg ? '0 : held_r;
    pot_bit   = MASK_W'(1) << q_head.pot;
    active    = q_head.pot_ok && (int'(q_head.mode) < MODE_COUNT);
    slot      = active ? SLOT_W'(q_head.pot) * SLOT_W'(MODE_COUNT) + SLOT_W'(q_head.mode)
                       : '0;
    stored    = store_r[slot];
    gap       = (q_head.level >= stored) ? q_head.level - stored : stored - q_head.level;
    if ((held_base & pot_bit) != '0) begin
      take = active && (stored != q_head.level);
    end else begin
      take = active && (gap <= LEVEL_W'(window_r));
    end
    held_nxt      = q_pop ? (held_base | (take ? pot_bit : '0)) : held_r;
    out_valid_nxt = q_pop ? 1'b1 : (out_valid_r && !out_ch.ready);

    out_ch.valid         = out_valid_r;
    out_ch.pot_out       = pot_r;
    out_ch.mode_out      = mode_r;
    out_ch.level         = level_r;
    out_ch.value_updated = updated_r;
    out_ch.control_mask  = held_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < POT_COUNT; p++) begin
        for (int m = 0; m < MODE_COUNT; m++) begin
          store_r[p * MODE_COUNT + m] <= default_level(p, m);
        end
      end
    end else if (q_pop && take) begin
      store_r[slot] <= q_head.level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_W'(WINDOW_RESET);
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      window_r    <= window_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pot_r     <= q_head.pot;
      mode_r    <= q_head.mode;
      level_r   <= q_head.level;
      updated_r <= take;
    end
  end

`ifndef SYNTHESIS
  a_update_means_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && updated_r |-> ((held_r >> pot_r) & MASK_W'(1)) != '0)
    else $error("value updated by a pot that does not hold control");
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(level_r))
    else $error("pending result changed before its transfer");
  a_mask_cleared_on_mode_change: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_head.mode_chg && !take |=> held_r == '0)
    else $error("control mask survived a mode change");
`endif

endmodule
`default_nettype wire
